>>> rtl/tcce_pkg.sv
// ----------------------------------------------------------------------------
// tcce_pkg
// Shared types and constants of the text console character engine: operation
// codes, sequencer states, character codes and default screen geometry.
// ----------------------------------------------------------------------------
package tcce_pkg;

  localparam int DEF_COLUMNS = 80;
  localparam int DEF_ROWS    = 25;

  localparam logic [15:0] BLANK_CELL   = 16'h0720;
  localparam logic [7:0]  COLOR_RESET  = 8'h0F;
  localparam logic [7:0]  CH_NEWLINE   = 8'd10;
  localparam logic [7:0]  CH_BACKSPACE = 8'd8;
  localparam logic [7:0]  CH_RETURN    = 8'd13;
  localparam logic [7:0]  CH_SPACE     = 8'd32;

  typedef enum logic [2:0] {
    OP_PUT   = 3'd0,
    OP_LEFT  = 3'd1,
    OP_RIGHT = 3'd2,
    OP_UP    = 3'd3,
    OP_DOWN  = 3'd4,
    OP_SET   = 3'd5,
    OP_CLEAR = 3'd6,
    OP_READ  = 3'd7
  } op_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_EXEC,
    ST_COPY,
    ST_FILL,
    ST_DONE
  } state_t;

endpackage

>>> rtl/tcce_ram.sv
// ----------------------------------------------------------------------------
// tcce_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while no read is issued.
// ----------------------------------------------------------------------------
module tcce_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> rtl/tcce_addr_unit.sv
// ----------------------------------------------------------------------------
// tcce_addr_unit
// Shared address unit: turns a row and a column into a linear cell offset
// (row * COLUMNS + col). Used for cell reads, cell writes and the cursor
// offset, one use per sequencer step.
// ----------------------------------------------------------------------------
module tcce_addr_unit import tcce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic [$clog2(ROWS)-1:0]         row,
  input  logic [$clog2(COLUMNS)-1:0]      col,
  output logic [$clog2(ROWS*COLUMNS)-1:0] addr
);

  localparam int AW = $clog2(ROWS * COLUMNS);

  logic [31:0] lin;

  assign lin  = 32'(row) * 32'(COLUMNS) + 32'(col);
  assign addr = lin[AW-1:0];

endmodule

>>> rtl/text_console_char_engine_unit.sv
// ----------------------------------------------------------------------------
// text_console_char_engine_unit
// Character-cell console engine. Holds the screen store, the text end of each
// row and the cursor; executes one console operation per input transfer and
// returns the cursor, its offset, the read cell and a scroll flag.
// ----------------------------------------------------------------------------
//
//  channel  | handshake             | payload
//  ---------+-----------------------+-------------------------------------------
//  in       | in_valid / in_ready   | opcode, char_code, target_row, target_col
//  out      | out_valid / out_ready | cursor_row, cursor_col, cursor_offset,
//           |                       | cell_data, scrolled
//  cfg      | cfg_valid / cfg_ready | cfg_data (text color attribute)
//
//  An ordinary operation passes through the execute and done states after its
//  input transfer; out_valid is registered from the done state. A scroll adds
//  a copy pass and a fill pass, and a clear repeats the reset sweep; both walk
//  the screen RAM one cell a cycle through its single write port. After reset
//  the ROWS*COLUMNS cells (2000 at 80x25) are swept to blanks with in_ready low;
//  cfg writes are taken at any time. in_ready is high only in the idle state;
//  a held result does not block the next input transfer, only the following result.
//
module text_console_char_engine_unit import tcce_pkg::*; #(
  parameter int COLUMNS = DEF_COLUMNS,
  parameter int ROWS    = DEF_ROWS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  opcode,
  input  logic [7:0]  char_code,
  input  logic [4:0]  target_row,
  input  logic [6:0]  target_col,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [4:0]  cursor_row,
  output logic [6:0]  cursor_col,
  output logic [10:0] cursor_offset,
  output logic [15:0] cell_data,
  output logic        scrolled,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int N    = ROWS * COLUMNS;
  localparam int LAST = (ROWS - 1) * COLUMNS;
  localparam int RW   = $clog2(ROWS);
  localparam int CW   = $clog2(COLUMNS);
  localparam int EW   = $clog2(COLUMNS + 1);
  localparam int AW   = $clog2(N);

  state_t state, state_next;

  logic [7:0]    text_color;
  logic [RW-1:0] cur_row, row_next;
  logic [CW-1:0] cur_col, col_next;
  logic [AW-1:0] sweep;
  logic          pending;

  op_t           op_q;
  logic [7:0]    ch_q;
  logic [RW-1:0] tr_q, tr_sat;
  logic [CW-1:0] tc_q, tc_sat;
  logic [31:0]   tr32, tc32;
  logic [15:0]   cell_q;
  logic          scrolled_q;

  logic in_fire, out_load;

  // address unit operands
  logic [RW-1:0] au_row;
  logic [CW-1:0] au_col;
  logic [AW-1:0] unit_addr;

  // RAM ports
  logic          scr_re, scr_we;
  logic [AW-1:0] scr_raddr, scr_waddr;
  logic [15:0]   scr_wdata, scr_rdata;
  logic          end_re, end_we;
  logic [RW-1:0] end_raddr, end_waddr, look_row;
  logic [EW-1:0] end_wdata, end_rdata;

  // execute step
  logic [31:0]   end_c32;
  logic [CW-1:0] end_clamp;
  logic          row_last;
  logic [RW-1:0] row_inc;
  logic [CW-1:0] ex_wcol;
  logic          ex_scr_we, ex_end_we, ex_scroll, ex_clear;
  logic [15:0]   ex_scr_data;
  logic [EW-1:0] ex_end_data;
  logic          look_up;
  op_t           op_in;

  tcce_ram #(.WIDTH(16), .DEPTH(N)) u_screen (
    .clk     (clk),
    .wr_en   (scr_we),
    .wr_addr (scr_waddr),
    .wr_data (scr_wdata),
    .rd_en   (scr_re),
    .rd_addr (scr_raddr),
    .rd_data (scr_rdata)
  );

  tcce_ram #(.WIDTH(EW), .DEPTH(ROWS)) u_row_end (
    .clk     (clk),
    .wr_en   (end_we),
    .wr_addr (end_waddr),
    .wr_data (end_wdata),
    .rd_en   (end_re),
    .rd_addr (end_raddr),
    .rd_data (end_rdata)
  );

  tcce_addr_unit #(.COLUMNS(COLUMNS), .ROWS(ROWS)) u_addr (
    .row  (au_row),
    .col  (au_col),
    .addr (unit_addr)
  );

  // saturate the target position to the screen
  assign tr32   = (32'(target_row) > 32'(ROWS - 1)) ? 32'(ROWS - 1) : 32'(target_row);
  assign tc32   = (32'(target_col) > 32'(COLUMNS - 1)) ? 32'(COLUMNS - 1) : 32'(target_col);
  assign tr_sat = tr32[RW-1:0];
  assign tc_sat = tc32[CW-1:0];

  assign end_c32   = (32'(end_rdata) > 32'(COLUMNS - 1)) ? 32'(COLUMNS - 1) : 32'(end_rdata);
  assign end_clamp = end_c32[CW-1:0];
  assign row_last  = (32'(cur_row) + 32'd1) >= 32'(ROWS);
  assign row_inc   = cur_row + RW'(1);

  // row-end lookup at accept: previous row for up and for moves that may leave column 0, next row for down
  assign op_in   = op_t'(opcode);
  assign look_up = (((op_in == OP_LEFT) || ((op_in == OP_PUT) && (char_code == CH_BACKSPACE)))
                    && (cur_col == '0)) || (op_in == OP_UP);

  always_comb begin
    look_row = cur_row;
    if (look_up && (cur_row != '0)) begin
      look_row = cur_row - RW'(1);
    end else if ((op_in == OP_DOWN) && !row_last) begin
      look_row = row_inc;
    end
  end

  // FSM outputs
  always_comb begin
    in_ready = (state == ST_IDLE);
    out_load = (state == ST_DONE) && (!out_valid || out_ready);
  end

  assign in_fire   = in_valid && in_ready;
  assign cfg_ready = 1'b1;

  // FSM next state
  always_comb begin
    state_next = state;
    case (state)
      ST_INIT: begin
        if (32'(sweep) == 32'(N - 1)) begin
          state_next = pending ? ST_DONE : ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_fire) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (ex_clear) begin
          state_next = ST_INIT;
        end else if (ex_scroll) begin
          state_next = ST_COPY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_COPY: begin
        if (32'(sweep) == 32'(LAST)) begin
          state_next = ST_FILL;
        end
      end
      ST_FILL: begin
        if (32'(sweep) == 32'(N - 1)) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_INIT;
    endcase
  end

  // execute one operation on the cursor, row end and cell
  always_comb begin
    row_next    = cur_row;
    col_next    = cur_col;
    ex_wcol     = cur_col;
    ex_scr_we   = 1'b0;
    ex_scr_data = {text_color, CH_SPACE};
    ex_end_we   = 1'b0;
    ex_end_data = end_rdata;
    ex_scroll   = 1'b0;
    ex_clear    = 1'b0;
    case (op_q)
      OP_PUT: begin
        if (ch_q == CH_NEWLINE) begin
          ex_end_we   = 1'b1;
          ex_end_data = EW'(cur_col);
          col_next    = '0;
          if (!row_last) begin
            row_next = row_inc;
          end else begin
            ex_scroll = 1'b1;
          end
        end else if (ch_q == CH_BACKSPACE) begin
          if (cur_col != '0) begin
            ex_wcol   = cur_col - CW'(1);
            col_next  = ex_wcol;
            ex_scr_we = 1'b1;
            if (32'(end_rdata) > 32'(ex_wcol)) begin
              ex_end_we   = 1'b1;
              ex_end_data = EW'(ex_wcol);
            end
          end else if (cur_row != '0) begin
            row_next = cur_row - RW'(1);
            col_next = end_clamp;
          end
        end else if (ch_q == CH_RETURN) begin
          col_next = '0;
        end else begin
          ex_scr_we   = 1'b1;
          ex_scr_data = {text_color, ch_q};
          if (32'(cur_col) >= 32'(end_rdata)) begin
            ex_end_we   = 1'b1;
            ex_end_data = EW'(32'(cur_col) + 32'd1);
          end
          if ((32'(cur_col) + 32'd1) >= 32'(COLUMNS)) begin
            col_next = '0;
            if (!row_last) begin
              row_next = row_inc;
            end else begin
              ex_scroll = 1'b1;
            end
          end else begin
            col_next = cur_col + CW'(1);
          end
        end
      end
      OP_LEFT: begin
        if (cur_col != '0) begin
          col_next = cur_col - CW'(1);
        end else if (cur_row != '0) begin
          row_next = cur_row - RW'(1);
          col_next = end_clamp;
        end
      end
      OP_RIGHT: begin
        if (cur_col < end_clamp) begin
          col_next = cur_col + CW'(1);
        end else if (!row_last) begin
          row_next = row_inc;
          col_next = '0;
        end
      end
      OP_UP: begin
        if (cur_row != '0) begin
          row_next = cur_row - RW'(1);
          if (cur_col > end_clamp) begin
            col_next = end_clamp;
          end
        end
      end
      OP_DOWN: begin
        if (!row_last) begin
          row_next = row_inc;
          if (cur_col > end_clamp) begin
            col_next = end_clamp;
          end
        end
      end
      OP_SET: begin
        row_next = tr_q;
        col_next = tc_q;
      end
      OP_CLEAR: begin
        row_next = '0;
        col_next = '0;
        ex_clear = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // address unit operand select
  always_comb begin
    case (state)
      ST_IDLE: begin
        au_row = tr_sat;
        au_col = tc_sat;
      end
      ST_EXEC: begin
        au_row = cur_row;
        au_col = ex_wcol;
      end
      default: begin
        au_row = cur_row;
        au_col = cur_col;
      end
    endcase
  end

  // memory port control
  always_comb begin
    scr_re    = 1'b0;
    scr_raddr = unit_addr;
    scr_we    = 1'b0;
    scr_waddr = sweep;
    scr_wdata = BLANK_CELL;
    end_re    = 1'b0;
    end_raddr = look_row;
    end_we    = 1'b0;
    end_waddr = cur_row;
    end_wdata = '0;
    case (state)
      ST_INIT: begin
        scr_we = 1'b1;
        if (32'(sweep) < 32'(ROWS)) begin
          end_we    = 1'b1;
          end_waddr = RW'(sweep);
        end
      end
      ST_IDLE: begin
        scr_re = in_fire;
        end_re = in_fire;
      end
      ST_EXEC: begin
        scr_we    = ex_scr_we;
        scr_waddr = unit_addr;
        scr_wdata = ex_scr_data;
        end_we    = ex_end_we;
        end_wdata = ex_end_data;
      end
      ST_COPY: begin
        // read one row ahead, write the previous read back one row up
        scr_re    = 32'(sweep) < 32'(LAST);
        scr_raddr = AW'(32'(sweep) + 32'(COLUMNS));
        scr_we    = (sweep != '0);
        scr_waddr = AW'(32'(sweep) - 32'd1);
        scr_wdata = scr_rdata;
        end_re    = (32'(sweep) + 32'd1) < 32'(ROWS);
        end_raddr = RW'(32'(sweep) + 32'd1);
        if ((sweep != '0) && (32'(sweep) < 32'(ROWS))) begin
          end_we    = 1'b1;
          end_waddr = RW'(32'(sweep) - 32'd1);
          end_wdata = end_rdata;
        end else if (32'(sweep) == 32'(ROWS)) begin
          end_we    = 1'b1;
          end_waddr = RW'(ROWS - 1);
        end
      end
      ST_FILL: begin
        scr_we    = 1'b1;
        scr_wdata = {text_color, CH_SPACE};
      end
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_INIT;
      sweep      <= '0;
      pending    <= 1'b0;
      cur_row    <= '0;
      cur_col    <= '0;
      text_color <= COLOR_RESET;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        text_color <= cfg_data;
      end
      case (state)
        ST_INIT, ST_FILL: sweep <= sweep + AW'(1);
        ST_COPY: begin
          if (32'(sweep) != 32'(LAST)) begin
            sweep <= sweep + AW'(1);
          end
        end
        ST_EXEC: begin
          sweep   <= '0;
          cur_row <= row_next;
          cur_col <= col_next;
        end
        default: begin
        end
      endcase
      if (in_fire) begin
        pending <= 1'b1;
      end else if (out_load) begin
        pending <= 1'b0;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      op_q <= op_in;
      ch_q <= char_code;
      tr_q <= tr_sat;
      tc_q <= tc_sat;
    end
    if (state == ST_EXEC) begin
      scrolled_q <= ex_scroll;
      cell_q     <= (op_q == OP_READ) ? scr_rdata : 16'h0000;
    end
    if (out_load) begin
      cursor_row    <= 5'(cur_row);
      cursor_col    <= 7'(cur_col);
      cursor_offset <= 11'(unit_addr);
      cell_data     <= cell_q;
      scrolled      <= scrolled_q;
    end
  end

`ifndef SYNTHESIS
  a_idle_not_pending: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !pending)
    else $error("idle while an operation is still pending");

  a_cursor_range: assert property (@(posedge clk) disable iff (rst)
    (32'(cur_row) < 32'(ROWS)) && (32'(cur_col) < 32'(COLUMNS)))
    else $error("cursor outside the screen");

  a_scroll_col0: assert property (@(posedge clk) disable iff (rst)
    (out_valid && scrolled) |-> (cursor_col == 7'd0))
    else $error("scroll reported with cursor off column 0");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> (!scr_we && !end_we))
    else $error("store written while idle");
`endif

endmodule
